// ===== hw/rtl/gaussian_polar_sampler_top_assert.svh =====
// Assertion macros used by the sampler top level.
// Each expects signals named clock and reset in the scope where it is used.
`ifndef GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gps_pkg.sv =====
package gps_pkg;

   // Register map of the configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STD_DEV = 2'd1;

   localparam logic signed [31:0] MEAN_RESET    = 32'sd0;
   localparam logic [31:0]        STD_DEV_RESET = 32'd65536;

   // 2 ln 2 in Q.32 is 2^32 + LN2X2_LO
   localparam logic [30:0] LN2X2_LO = 31'd1659121648;

   // -2 ln s in Q.32 reaches about 86 * 2^32, so it needs 39 bits
   localparam int W_BITS = 39;

   // Iteration counts of the log, divide and square-root pipelines
   localparam int LOG_STEPS  = 32;
   // (w << 23) / m stays below 2^31
   localparam int DIV_STEPS  = 31;
   // Low bits of w shifted into the divider after its first remainder
   localparam int DIV_LO_W   = W_BITS - DIV_STEPS;
   // Quotient after the odd-exponent doubling
   localparam int QD_W       = DIV_STEPS + 1;
   // The radicand is (qd << 24): twelve all-zero bit pairs at the bottom
   localparam int SQRT_ZERO_PAIRS = 12;
   localparam int SQRT_STEPS = QD_W / 2 + SQRT_ZERO_PAIRS;

   // What travels with a pair down the pipeline
   typedef struct packed {
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg_a;
      logic        neg_b;
      logic [5:0]  expo;
   } pair_info_type;

endpackage

// ===== hw/rtl/gps_if.sv =====
interface gps_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] rand_a;
   logic [31:0] rand_b;
   modport source (output valid, output rand_a, output rand_b, input ready);
   modport sink (input valid, input rand_a, input rand_b, output ready);
endinterface

interface gps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic               last;
   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface gps_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/gps_log2.sv =====
module gps_log2 import gps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [31:0]       in_m,
   input  pair_info_type     in_info,
   output logic              out_vld,
   output logic [W_BITS-1:0] out_w,
   output logic [31:0]       out_m,
   output pair_info_type     out_info
);

   logic          vld_ff  [LOG_STEPS];
   logic [31:0]   x_ff    [LOG_STEPS];
   logic [31:0]   frac_ff [LOG_STEPS];
   logic [31:0]   m_ff    [LOG_STEPS];
   pair_info_type info_ff [LOG_STEPS];

   // One squaring per stage, one fraction bit per stage
   for (genvar i = 0; i < LOG_STEPS; i++) begin : g_stage
      logic          p_vld;
      logic [31:0]   p_x;
      logic [31:0]   p_f;
      logic [31:0]   p_m;
      pair_info_type p_info;
      logic [63:0]   sq;
      logic [32:0]   x2;
      logic [31:0]   x_in;
      logic [31:0]   frac_in;

      if (i == 0) begin : g_first
         assign p_vld  = in_vld;
         assign p_x    = in_m;
         assign p_f    = '0;
         assign p_m    = in_m;
         assign p_info = in_info;
      end else begin : g_next
         assign p_vld  = vld_ff[i-1];
         assign p_x    = x_ff[i-1];
         assign p_f    = frac_ff[i-1];
         assign p_m    = m_ff[i-1];
         assign p_info = info_ff[i-1];
      end

      always_comb begin
         sq      = 64'(p_x) * 64'(p_x);
         x2      = sq[63:31];
         x_in    = x2[32] ? x2[32:1] : x2[31:0];
         frac_in = {p_f[30:0], x2[32]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            frac_ff[i] <= frac_in;
            m_ff[i]    <= p_m;
            info_ff[i] <= p_info;
         end
      end
   end

   // -log2 s in Q.24
   logic          nl_vld_ff;
   logic [29:0]   nl_ff;
   logic [29:0]   nl_in;
   logic [37:0]   nl_diff;
   logic [31:0]   nl_m_ff;
   pair_info_type nl_info_ff;

   always_comb begin
      nl_diff = {info_ff[LOG_STEPS-1].expo, 32'd0} - {6'd0, frac_ff[LOG_STEPS-1]};
      nl_in   = nl_diff[37:8];
   end

   // -2 ln s in Q.32, multiplier split as 2^32 plus a 31-bit low part
   logic              w_vld_ff;
   logic [W_BITS-1:0] w_ff;
   logic [W_BITS-1:0] w_in;
   logic [63:0]       w_prod;
   logic [31:0]       w_m_ff;
   pair_info_type     w_info_ff;

   always_comb begin
      w_prod = {2'd0, nl_ff, 32'd0} + 64'(nl_ff) * 64'(LN2X2_LO) + 64'(1 << 23);
      w_in   = w_prod[W_BITS+23:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nl_vld_ff <= 1'b0;
         w_vld_ff  <= 1'b0;
      end else if (en) begin
         nl_vld_ff <= vld_ff[LOG_STEPS-1];
         w_vld_ff  <= nl_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff      <= nl_in;
         nl_m_ff    <= m_ff[LOG_STEPS-1];
         nl_info_ff <= info_ff[LOG_STEPS-1];
         w_ff       <= w_in;
         w_m_ff     <= nl_m_ff;
         w_info_ff  <= nl_info_ff;
      end
   end

   assign out_vld  = w_vld_ff;
   assign out_w    = w_ff;
   assign out_m    = w_m_ff;
   assign out_info = w_info_ff;

endmodule

// ===== hw/rtl/gps_div.sv =====
module gps_div import gps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic [W_BITS-1:0]    in_w,
   input  logic [31:0]          in_m,
   input  pair_info_type        in_info,
   output logic                 out_vld,
   output logic [DIV_STEPS-1:0] out_q,
   output pair_info_type        out_info
);

   logic                 vld_ff  [DIV_STEPS];
   logic [31:0]          rem_ff  [DIV_STEPS];
   logic [DIV_LO_W-1:0]  lo_ff   [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff    [DIV_STEPS];
   logic [31:0]          m_ff    [DIV_STEPS];
   pair_info_type        info_ff [DIV_STEPS];

   // Restoring division of (w << 23) by m, one quotient bit per stage.
   // The first remainder is w >> DIV_LO_W, below m; the low bits of w
   // and then zeros are shifted in.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
      logic                 p_vld;
      logic [31:0]          p_rem;
      logic [DIV_LO_W-1:0]  p_lo;
      logic [DIV_STEPS-1:0] p_q;
      logic [31:0]          p_m;
      pair_info_type        p_info;
      logic [32:0]          rem2;
      logic [32:0]          diff;
      logic                 ge;
      logic [31:0]          rem_in;
      logic [DIV_LO_W-1:0]  lo_in;
      logic [DIV_STEPS-1:0] q_in;

      if (i == 0) begin : g_first
         assign p_vld  = in_vld;
         assign p_rem  = 32'(in_w[W_BITS-1:DIV_LO_W]);
         assign p_lo   = in_w[DIV_LO_W-1:0];
         assign p_q    = '0;
         assign p_m    = in_m;
         assign p_info = in_info;
      end else begin : g_next
         assign p_vld  = vld_ff[i-1];
         assign p_rem  = rem_ff[i-1];
         assign p_lo   = lo_ff[i-1];
         assign p_q    = q_ff[i-1];
         assign p_m    = m_ff[i-1];
         assign p_info = info_ff[i-1];
      end

      always_comb begin
         rem2   = {p_rem, p_lo[DIV_LO_W-1]};
         diff   = rem2 - {1'b0, p_m};
         ge     = (rem2 >= {1'b0, p_m});
         rem_in = ge ? diff[31:0] : rem2[31:0];
         lo_in  = {p_lo[DIV_LO_W-2:0], 1'b0};
         q_in   = {p_q[DIV_STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            lo_ff[i]   <= lo_in;
            q_ff[i]    <= q_in;
            m_ff[i]    <= p_m;
            info_ff[i] <= p_info;
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STEPS-1];
   assign out_q    = q_ff[DIV_STEPS-1];
   assign out_info = info_ff[DIV_STEPS-1];

endmodule

// ===== hw/rtl/gps_sqrt.sv =====
module gps_sqrt import gps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [DIV_STEPS-1:0]  in_q,
   input  pair_info_type         in_info,
   output logic                  out_vld,
   output logic [SQRT_STEPS-1:0] out_root,
   output pair_info_type         out_info
);

   logic                  vld_ff  [SQRT_STEPS];
   logic [QD_W-1:0]       qd_ff   [SQRT_STEPS];
   logic [SQRT_STEPS+1:0] rem_ff  [SQRT_STEPS];
   logic [SQRT_STEPS-1:0] root_ff [SQRT_STEPS];
   pair_info_type         info_ff [SQRT_STEPS];

   // Double the quotient when the exponent is odd
   logic [QD_W-1:0] qd_first;
   assign qd_first = in_info.expo[0] ? {in_q, 1'b0} : {1'b0, in_q};

   // Digit-by-digit root of (qd << 24), one root bit per stage
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
      localparam int K = SQRT_STEPS - 1 - i;
      logic                  p_vld;
      logic [QD_W-1:0]       p_qd;
      logic [SQRT_STEPS+1:0] p_rem;
      logic [SQRT_STEPS-1:0] p_root;
      pair_info_type         p_info;
      logic [1:0]            pair;
      logic [SQRT_STEPS+3:0] cur;
      logic [SQRT_STEPS+3:0] trial;
      logic [SQRT_STEPS+3:0] diff;
      logic                  ge;
      logic [SQRT_STEPS+1:0] rem_in;
      logic [SQRT_STEPS-1:0] root_in;

      if (i == 0) begin : g_first
         assign p_vld  = in_vld;
         assign p_qd   = qd_first;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_info = in_info;
      end else begin : g_next
         assign p_vld  = vld_ff[i-1];
         assign p_qd   = qd_ff[i-1];
         assign p_rem  = rem_ff[i-1];
         assign p_root = root_ff[i-1];
         assign p_info = info_ff[i-1];
      end

      // The low part of the radicand is all zero
      if (K >= SQRT_ZERO_PAIRS) begin : g_pair
         assign pair = p_qd[2*(K-SQRT_ZERO_PAIRS)+1 : 2*(K-SQRT_ZERO_PAIRS)];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      always_comb begin
         cur     = {p_rem, pair};
         trial   = {2'b00, p_root, 2'b01};
         diff    = cur - trial;
         ge      = (cur >= trial);
         rem_in  = ge ? diff[SQRT_STEPS+1:0] : cur[SQRT_STEPS+1:0];
         root_in = {p_root[SQRT_STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            qd_ff[i]   <= p_qd;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            info_ff[i] <= p_info;
         end
      end
   end

   assign out_vld  = vld_ff[SQRT_STEPS-1];
   assign out_root = root_ff[SQRT_STEPS-1];
   assign out_info = info_ff[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/gps_emit.sv =====
module gps_emit import gps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [SQRT_STEPS-1:0] in_root,
   input  pair_info_type         in_info,
   input  logic signed [31:0]    mean,
   input  logic [31:0]           std_dev,
   output logic                  out_vld,
   output logic [1:0][31:0]      out_sample
);

   localparam int Z_W = 32 + SQRT_STEPS;

   logic e1_vld_ff, e2_vld_ff, e3_vld_ff, e4_vld_ff;

   logic [Z_W-1:0] e1_z_ff   [2];
   logic           e1_neg_ff [2];
   logic [4:0]     e1_sh_ff;
   logic [31:0]    e2_z_ff   [2];
   logic           e2_neg_ff [2];
   logic [39:0]    e3_y_ff   [2];
   logic           e3_neg_ff [2];
   logic [31:0]    e4_s_ff   [2];

   logic [31:0] lane_mag [2];
   logic        lane_neg [2];
   logic [4:0]  sh_in;

   assign lane_mag[0] = in_info.mag_a;
   assign lane_mag[1] = in_info.mag_b;
   assign lane_neg[0] = in_info.neg_a;
   assign lane_neg[1] = in_info.neg_b;
   // Shift is 31 - (expo >> 1)
   assign sh_in       = ~in_info.expo[5:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
         e3_vld_ff <= 1'b0;
         e4_vld_ff <= 1'b0;
      end else if (en) begin
         e1_vld_ff <= in_vld;
         e2_vld_ff <= e1_vld_ff;
         e3_vld_ff <= e2_vld_ff;
         e4_vld_ff <= e3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_sh_ff <= sh_in;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [Z_W-1:0]     z_in;
      logic [Z_W-1:0]     rnd;
      logic [Z_W-1:0]     zr;
      logic [Z_W-1:0]     zs;
      logic [31:0]        zc_in;
      logic [63:0]        prod;
      logic [39:0]        y_in;
      logic signed [40:0] sy;
      logic signed [41:0] sum;
      logic [31:0]        s_in;

      // Scale |v| by the root
      assign z_in = Z_W'(lane_mag[l]) * Z_W'(in_root);

      // Round half up to Q.24 and clamp at 2^31, that is 128.0
      always_comb begin
         rnd   = (e1_sh_ff == 5'd0) ? '0 : (Z_W'(1) << (e1_sh_ff - 5'd1));
         zr    = e1_z_ff[l] + rnd;
         zs    = zr >> e1_sh_ff;
         zc_in = (zs > Z_W'(32'h8000_0000)) ? 32'h8000_0000 : zs[31:0];
      end

      // Apply the scale
      always_comb begin
         prod = 64'(e2_z_ff[l]) * 64'(std_dev) + 64'(1 << 23);
         y_in = prod[63:24];
      end

      // Apply sign and offset, saturate
      always_comb begin
         sy  = e3_neg_ff[l] ? -$signed({1'b0, e3_y_ff[l]}) : $signed({1'b0, e3_y_ff[l]});
         sum = 42'(sy) + 42'(mean);
         if (sum > 42'sd2147483647) begin
            s_in = 32'h7FFF_FFFF;
         end else if (sum < -42'sd2147483648) begin
            s_in = 32'h8000_0000;
         end else begin
            s_in = sum[31:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e1_z_ff[l]   <= z_in;
            e1_neg_ff[l] <= lane_neg[l];
            e2_z_ff[l]   <= zc_in;
            e2_neg_ff[l] <= e1_neg_ff[l];
            e3_y_ff[l]   <= y_in;
            e3_neg_ff[l] <= e2_neg_ff[l];
            e4_s_ff[l]   <= s_in;
         end
      end

      assign out_sample[l] = e4_s_ff[l];
   end

   assign out_vld = e4_vld_ff;

endmodule

// ===== hw/rtl/gaussian_polar_sampler_top.sv =====
// Gaussian sampler by the polar method, fixed point.
// req carries a pair of 32-bit uniform words (rand_a, rand_b). A pair whose
// squared radius is zero or not below one is dropped without a result.
// Every other pair gives two beats on rsp: the sample from rand_a with
// last low, then the sample from rand_b with last high, signed Q16.16.
// csr writes mean (index 0) and std_dev (index 1); other indexes are
// ignored. It is always ready; write it only while the block is idle.
// A pair passes the input stages, log, divide and root pipelines and
// output arithmetic into the output register; its second sample follows
// in the cycle after the first is taken. One pair per cycle can enter
// while nothing stalls; rsp takes two beats a pair and sets the rate.
// A stall on rsp freezes the whole pipeline once a finished pair waits
// behind the output register; req.ready then drops and nothing is lost.
// Reset (synchronous) empties the pipeline and sets mean to 0 and
// std_dev to 1.0.
`include "gaussian_polar_sampler_top_assert.svh"

module gaussian_polar_sampler_top import gps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gps_req_if.sink   req,
   gps_rsp_if.source rsp,
   gps_csr_if.sink   csr
);

   logic signed [31:0] mean_ff;
   logic [31:0]        std_dev_ff;

   // Configuration registers
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff    <= MEAN_RESET;
         std_dev_ff <= STD_DEV_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_MEAN:    mean_ff    <= csr.data;
            CSR_STD_DEV: std_dev_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Pipeline advance: all stages move together
   logic          adv;
   logic          ob_free;
   logic          ob_vld_ff;
   logic          ob_idx_ff;
   logic [31:0]   ob_s0_ff;
   logic [31:0]   ob_s1_ff;
   logic          emit_vld;
   logic [1:0][31:0] emit_sample;

   assign ob_free   = !ob_vld_ff || (rsp.ready && ob_idx_ff);
   assign adv       = ob_free || !emit_vld;
   assign req.ready = adv;

   // Stage 0: magnitudes and signs of v
   logic          s0_vld_ff;
   pair_info_type s0_info_ff;
   pair_info_type s0_info_in;

   always_comb begin
      s0_info_in.mag_a = req.rand_a[31] ? {1'b0, req.rand_a[30:0]}
                                        : 32'h8000_0000 - {1'b0, req.rand_a[30:0]};
      s0_info_in.mag_b = req.rand_b[31] ? {1'b0, req.rand_b[30:0]}
                                        : 32'h8000_0000 - {1'b0, req.rand_b[30:0]};
      s0_info_in.neg_a = ~req.rand_a[31];
      s0_info_in.neg_b = ~req.rand_b[31];
      s0_info_in.expo  = '0;
   end

   // Stage 1: squares
   logic          s1_vld_ff;
   logic [63:0]   s1_sqa_ff, s1_sqb_ff;
   pair_info_type s1_info_ff;

   // Stage 2: sum, reject out of the unit circle or at the origin
   logic          s2_vld_ff;
   logic [61:0]   s2_s_ff;
   pair_info_type s2_info_ff;
   logic [63:0]   s_in;
   logic          rej;

   assign s_in = s1_sqa_ff + s1_sqb_ff;
   assign rej  = (s_in == 64'd0) || (s_in[63:62] != 2'b00);

   // Stage 3: coarse normalise (32, 16, 8)
   logic          n1_vld_ff;
   logic [61:0]   n1_t_ff;
   logic [2:0]    n1_lz_ff;
   pair_info_type n1_info_ff;
   logic [61:0]   n1_t_in;
   logic [2:0]    n1_lz_in;

   always_comb begin
      n1_t_in  = s2_s_ff;
      n1_lz_in = '0;
      if (n1_t_in[61:30] == '0) begin
         n1_t_in     = n1_t_in << 32;
         n1_lz_in[2] = 1'b1;
      end
      if (n1_t_in[61:46] == '0) begin
         n1_t_in     = n1_t_in << 16;
         n1_lz_in[1] = 1'b1;
      end
      if (n1_t_in[61:54] == '0) begin
         n1_t_in     = n1_t_in << 8;
         n1_lz_in[0] = 1'b1;
      end
   end

   // Stage 4: fine normalise (4, 2, 1), mantissa and exponent
   logic          n2_vld_ff;
   logic [31:0]   n2_m_ff;
   pair_info_type n2_info_ff;
   logic [61:0]   n2_t;
   logic [5:0]    n2_lz;
   pair_info_type n2_info_in;

   always_comb begin
      n2_t  = n1_t_ff;
      n2_lz = {n1_lz_ff, 3'b000};
      if (n2_t[61:58] == '0) begin
         n2_t     = n2_t << 4;
         n2_lz[2] = 1'b1;
      end
      if (n2_t[61:60] == '0) begin
         n2_t     = n2_t << 2;
         n2_lz[1] = 1'b1;
      end
      if (!n2_t[61]) begin
         n2_t     = n2_t << 1;
         n2_lz[0] = 1'b1;
      end
      n2_info_in      = n1_info_ff;
      n2_info_in.expo = n2_lz + 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         n1_vld_ff <= 1'b0;
         n2_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req.valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff && !rej;
         n1_vld_ff <= s2_vld_ff;
         n2_vld_ff <= n1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_info_ff <= s0_info_in;
         s1_sqa_ff  <= 64'(s0_info_ff.mag_a) * 64'(s0_info_ff.mag_a);
         s1_sqb_ff  <= 64'(s0_info_ff.mag_b) * 64'(s0_info_ff.mag_b);
         s1_info_ff <= s0_info_ff;
         s2_s_ff    <= s_in[61:0];
         s2_info_ff <= s1_info_ff;
         n1_t_ff    <= n1_t_in;
         n1_lz_ff   <= n1_lz_in;
         n1_info_ff <= s2_info_ff;
         n2_m_ff    <= n2_t[61:30];
         n2_info_ff <= n2_info_in;
      end
   end

   // Log, divide, root and output arithmetic
   logic                  log_vld;
   logic [W_BITS-1:0]     log_w;
   logic [31:0]           log_m;
   pair_info_type         log_info;
   logic                  div_vld;
   logic [DIV_STEPS-1:0]  div_q;
   pair_info_type         div_info;
   logic                  sqrt_vld;
   logic [SQRT_STEPS-1:0] sqrt_root;
   pair_info_type         sqrt_info;

   gps_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (n2_vld_ff),
      .in_m     (n2_m_ff),
      .in_info  (n2_info_ff),
      .out_vld  (log_vld),
      .out_w    (log_w),
      .out_m    (log_m),
      .out_info (log_info)
   );

   gps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (log_vld),
      .in_w     (log_w),
      .in_m     (log_m),
      .in_info  (log_info),
      .out_vld  (div_vld),
      .out_q    (div_q),
      .out_info (div_info)
   );

   gps_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (div_vld),
      .in_q     (div_q),
      .in_info  (div_info),
      .out_vld  (sqrt_vld),
      .out_root (sqrt_root),
      .out_info (sqrt_info)
   );

   gps_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_vld     (sqrt_vld),
      .in_root    (sqrt_root),
      .in_info    (sqrt_info),
      .mean       (mean_ff),
      .std_dev    (std_dev_ff),
      .out_vld    (emit_vld),
      .out_sample (emit_sample)
   );

   // Output register: holds a pair, sends it as two beats
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_vld_ff <= 1'b0;
         ob_idx_ff <= 1'b0;
      end else if (ob_free && emit_vld) begin
         ob_vld_ff <= 1'b1;
         ob_idx_ff <= 1'b0;
      end else if (ob_vld_ff && rsp.ready) begin
         if (ob_idx_ff) begin
            ob_vld_ff <= 1'b0;
            ob_idx_ff <= 1'b0;
         end else begin
            ob_idx_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ob_free && emit_vld) begin
         ob_s0_ff <= emit_sample[0];
         ob_s1_ff <= emit_sample[1];
      end
   end

   assign rsp.valid  = ob_vld_ff;
   assign rsp.sample = ob_idx_ff ? ob_s1_ff : ob_s0_ff;
   assign rsp.last   = ob_idx_ff;

   `GPS_ASSERT_NEXT(a_second_beat, rsp.valid && rsp.ready && !rsp.last, rsp.valid && rsp.last, "second sample of a pair did not follow the first")
   `GPS_ASSERT_SAME(a_stall_cause, !req.ready, rsp.valid, "input stalled without a waiting result")
   `GPS_ASSERT_NEXT(a_stall_hold, !adv, $stable(emit_vld) && $stable(emit_sample), "pipeline moved during a stall")

endmodule

// ===== dv/tb_gaussian_polar_sampler_top.sv =====
module tb_gaussian_polar_sampler_top;
   import gps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Indexes outside the register map; writes to them must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [31:0] MID_WORD = 32'h8000_0000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic signed [31:0] sample;
      logic               last;
   } sample_beat_type;

   logic clock;
   logic reset;

   gps_req_if req_if ();
   gps_rsp_if rsp_if ();
   gps_csr_if csr_if ();

   gaussian_polar_sampler_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Own copy of the registers
   logic signed [31:0] mean_q16;
   logic [31:0]        std_dev_q16;

   sample_beat_type expected_samples[$];
   int errors;
   int burst_left;
   int gap_max;
   int hold_off_cycles;
   int stall_pct;

   always #1 clock = ~clock;

   // Scale one magnitude by the polar factor, apply std_dev, sign and mean
   function automatic logic [31:0] scale_sample(input bit [63:0] vmag, input bit neg,
                                                input bit [63:0] root, input int h);
      int sh;
      bit [63:0] z;
      bit [63:0] y;
      longint val;
      sh = 31 - h;
      z = vmag * root;
      if (sh > 0)
         z = (z + (64'd1 << (sh - 1))) >> sh;
      if (z > (64'd1 << 31))
         z = 64'd1 << 31;
      y = (z * {32'd0, std_dev_q16} + (64'd1 << 23)) >> 24;
      val = neg ? -longint'(y) : longint'(y);
      val += longint'(mean_q16);
      if (val > 64'sd2147483647)
         val = 64'sd2147483647;
      if (val < -64'sd2147483648)
         val = -64'sd2147483648;
      return val[31:0];
   endfunction

   // Work out the two samples of a pair, or nothing if the pair is rejected
   function automatic void predict_polar_pair(input logic [31:0] word_a, input logic [31:0] word_b);
      longint v1, v2;
      bit [63:0] a1, a2, s, m, x, frac, nl, w, q, rem, res, bitv;
      int p, e, h;
      sample_beat_type beat;
      v1 = longint'({32'd0, word_a}) - 64'sd2147483648;
      v2 = longint'({32'd0, word_b}) - 64'sd2147483648;
      a1 = v1 < 0 ? -v1 : v1;
      a2 = v2 < 0 ? -v2 : v2;
      s = a1 * a1 + a2 * a2;
      if (s == 0 || s >= (64'd1 << 62))
         return;
      p = 61;
      while (!s[p])
         p--;
      e = 62 - p;
      m = (p >= 31) ? (s >> (p - 31)) : (s << (31 - p));
      // log2 fraction by repeated squaring
      x = m;
      frac = 0;
      for (int i = 0; i < 32; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= (64'd1 << 32)) begin
            x = x >> 1;
            frac[0] = 1'b1;
         end
      end
      nl = ((64'(e) << 32) - frac) >> 8;
      w = (nl * 64'd5954088944 + (64'd1 << 23)) >> 24;
      q = (w << 23) / m;
      if (e % 2 == 1)
         q = q << 1;
      // integer square root, floor
      rem = q << 24;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem)
         bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      h = e >> 1;
      beat.sample = scale_sample(a1, v1 < 0, res, h);
      beat.last = 1'b0;
      expected_samples.push_back(beat);
      beat.sample = scale_sample(a2, v2 < 0, res, h);
      beat.last = 1'b1;
      expected_samples.push_back(beat);
   endfunction

   // Offer one pair, honouring the burst pattern, and predict on acceptance
   task automatic send_pair(input logic [31:0] word_a, input logic [31:0] word_b);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max > 0 && $urandom_range(0, 2) != 0)
            gap = $urandom_range(1, gap_max);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.rand_a <= word_a;
      req_if.rand_b <= word_b;
      do @(posedge clock); while (!req_if.ready);
      predict_polar_pair(word_a, word_b);
   endtask

   // Drop valid and let the pipeline empty, including dropped pairs in flight
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (expected_samples.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_MEAN)
         mean_q16 = value;
      else if (idx == CSR_STD_DEV)
         std_dev_q16 = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Random word, sometimes close to the midpoint so that s gets tiny
   function automatic logic [31:0] rand_word();
      logic [31:0] off;
      if ($urandom_range(0, 3) != 0)
         return $urandom();
      off = $urandom() >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? MID_WORD + off : MID_WORD - off;
   endfunction

   task automatic test_directed();
      send_pair(MID_WORD, MID_WORD);                   // zero radius
      send_pair(32'h0000_0000, 32'h0000_0000);         // far outside the circle
      send_pair(32'hFFFF_FFFF, MID_WORD);              // radius just under one
      send_pair(32'h0000_0001, MID_WORD);              // radius just under one, negative
      send_pair(32'h0000_0000, MID_WORD);              // radius exactly one
      send_pair(MID_WORD + 1, MID_WORD);               // smallest non-zero radius
      send_pair(MID_WORD, MID_WORD - 1);
      send_pair(MID_WORD + 3, MID_WORD - 2);
      send_pair(32'hC000_0000, 32'h4000_0000);
      send_pair(32'hB504_F333, 32'hB504_F333);         // radius about 0.59, inside the circle
      send_pair(32'hA000_0000, 32'h6000_0000);
      send_pair(32'h8000_FFFF, 32'h7FFF_0000);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);         // outside, both at top
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);
      // saturation on both sides
      write_reg(CSR_STD_DEV, 32'hFFFF_FFFF);
      write_reg(CSR_MEAN, 32'h7FFF_FFFF);
      send_pair(32'hF000_0000, MID_WORD + 5);
      send_pair(32'h1000_0000, MID_WORD - 5);
      write_reg(CSR_MEAN, 32'h8000_0000);
      send_pair(32'hF000_0000, MID_WORD + 5);
      send_pair(32'h1000_0000, MID_WORD - 5);
      write_reg(CSR_STD_DEV, 32'h0000_0000);
      send_pair(32'hC000_0000, 32'h4000_0000);
      // writes outside the map leave the registers alone
      write_reg(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_HI, 32'h1234_5678);
      send_pair(32'hD000_0000, 32'h3000_0000);
      write_reg(CSR_MEAN, MEAN_RESET);
      write_reg(CSR_STD_DEV, STD_DEV_RESET);
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MEAN, MEAN_RESET);
               write_reg(CSR_STD_DEV, STD_DEV_RESET);
            end
            1: begin
               write_reg(CSR_MEAN, $urandom());
               write_reg(CSR_STD_DEV, $urandom());
            end
            2: begin
               write_reg(CSR_MEAN, 32'h7FFF_FFFF);
               write_reg(CSR_STD_DEV, 32'hFFFF_FFFF);
            end
            3: begin
               write_reg(CSR_MEAN, 32'h8000_0000);
               write_reg(CSR_STD_DEV, $urandom_range(0, 32'h0004_0000));
            end
            4: begin
               write_reg(CSR_MEAN, $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
               write_reg(CSR_STD_DEV, 32'd0);
            end
            default: begin
               write_reg(CSR_MEAN, $urandom());
               write_reg(CSR_STD_DEV, $urandom_range(1, 32'h0010_0000));
            end
         endcase
         // alternate stretches with and without sender gaps
         gap_max = (phase % 2 == 0) ? 6 : 0;
         for (int n = 0; n < 55; n++)
            send_pair(rand_word(), rand_word());
      end
      gap_max = 6;
   endtask

   // Hold the receiver off while the sender keeps offering pairs;
   // more pairs than the pipeline holds, so the input stalls
   task automatic test_backpressure();
      write_reg(CSR_MEAN, $urandom());
      write_reg(CSR_STD_DEV, STD_DEV_RESET);
      gap_max = 0;
      hold_off_cycles = 400;
      for (int n = 0; n < 200; n++)
         send_pair($urandom(), $urandom());
      gap_max = 6;
   endtask

   // Receiver stall pattern: ready held low during a hold-off, else dropped at a stall rate redrawn at random
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      sample_beat_type exp_beat;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected result beat: sample %0d last %0b", rsp_if.sample, rsp_if.last);
            errors++;
         end else begin
            exp_beat = expected_samples.pop_front();
            if (rsp_if.sample !== exp_beat.sample) begin
               $error("sample: expected %0d, actual %0d", exp_beat.sample, rsp_if.sample);
               errors++;
            end
            if (rsp_if.last !== exp_beat.last) begin
               $error("last: expected %0b, actual %0b", exp_beat.last, rsp_if.last);
               errors++;
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.rand_a = '0;
      req_if.rand_b = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      mean_q16 = MEAN_RESET;
      std_dev_q16 = STD_DEV_RESET;
      errors = 0;
      burst_left = 0;
      gap_max = 6;
      hold_off_cycles = 0;
      stall_pct = 20;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random();
      test_backpressure();

      wait_idle();
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gps_pkg.sv
hw/rtl/gps_if.sv
hw/rtl/gps_log2.sv
hw/rtl/gps_div.sv
hw/rtl/gps_sqrt.sv
hw/rtl/gps_emit.sv
hw/rtl/gaussian_polar_sampler_top.sv
dv/tb_gaussian_polar_sampler_top.sv
